[hdl/ccmr_pkg.sv]
// Shared constants for the cluster centroid / mean radius core.
// No dependencies; imported by the top level.
package ccmr_pkg;
	localparam int MAX_POINTS_DEF  = 1024;
	localparam int COORD_WIDTH_DEF = 24;
	localparam int COUNT_OUT_W     = 11;   // width of the point_count field
endpackage

[hdl/ccmr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ccmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/ccmr_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// No dependencies; used by the top level for the centroid and the mean.
module ccmr_div #(
	parameter int N_W = 16,
	parameter int D_W = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);
	localparam int CW = $clog2(N_W + 1);

	logic [D_W:0]   rem_q;
	logic [N_W-1:0] quo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [D_W:0]   rem_sh;
	logic           ge;
	logic [D_W:0]   rem_nx;

	assign rem_sh = {rem_q[D_W-1:0], quo_q[N_W-1]};
	assign ge     = rem_sh >= {1'b0, divisor};
	assign rem_nx = ge ? rem_sh - {1'b0, divisor} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q && !done_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q < CW'(N_W))
		else $error("divider step count out of range");
endmodule

[hdl/cluster_centroid_mean_radius_core.sv]
// Channel  | dir | handshake                    | content
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | one point per word, tlast closes the cluster
// m_axis   | out | m_axis_tvalid/m_axis_tready  | one result word per cluster
// Points load at one per cycle into the point RAM while s_axis_tready is high. At the last
// point the core runs the centroid division (DIV_W = COORD_WIDTH+1+count bits), then for
// each stored point a RAM read, difference, square, and one root bit per cycle in the
// square-root loop, then the mean division, and then loads the result register once no
// previous result is pending or m_axis_tready is high.
// Input is held off from the last point until the result is registered; a result
// waiting on m_axis_tready does not block loading of the next cluster.
// Reset clears counters, sums and flags; the point RAM is not cleared.
module cluster_centroid_mean_radius_core
	import ccmr_pkg::*;
#(
	parameter int MAX_POINTS  = MAX_POINTS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// point_x, point_y, zero pad
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input  logic s_axis_tlast,                 // last_point
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// centroid_x, centroid_y, mean_radius, point_count, overflowed, zero pad
	output logic [((3*COORD_WIDTH+13+7)/8)*8-1:0] m_axis_tdata
);
	localparam int CW     = COORD_WIDTH;
	localparam int AW     = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int SUM_W  = CW + CNT_W;
	localparam int R_W    = CW + 1;
	localparam int SQ_W   = 2 * R_W;
	localparam int DIV_W  = R_W + CNT_W;
	localparam int STEP_W = $clog2(R_W + 1);
	localparam int OUT_W  = ((3*CW+13+7)/8)*8;
	localparam int PAD_W  = OUT_W - (3*CW + 13);

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_CDIV = 4'd1;
	localparam logic [3:0] ST_RD   = 4'd2;
	localparam logic [3:0] ST_DAT  = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_SQL  = 4'd5;
	localparam logic [3:0] ST_SQRT = 4'd6;
	localparam logic [3:0] ST_RDIV = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        idx_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic                    drop_q;
	logic                    start_q;
	logic signed [CW-1:0]    cx_q, cy_q;
	logic [R_W-1:0]          adx_q, ady_q;
	logic [SQ_W-1:0]         sqx_q, sqy_q;
	logic [SQ_W-1:0]         n_q, root_q, bit_q;
	logic [STEP_W-1:0]       step_q;
	logic [DIV_W-1:0]        dist_q;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;

	logic                    accept, full, mem_we;
	logic                    out_load;
	logic signed [CW-1:0]    in_x, in_y;
	logic [2*CW-1:0]         rdata;
	logic [SUM_W-1:0]        mag_x, mag_y;
	logic [DIV_W-1:0]        dvd_x;
	logic [DIV_W-1:0]        q_x, q_y;
	logic                    done_x, done_y;
	logic signed [R_W-1:0]   dx, dy;
	logic [SQ_W-1:0]         trial, n_nx, root_nx;
	logic                    fit;

	assign in_x   = s_axis_tdata[CW-1:0];
	assign in_y   = s_axis_tdata[2*CW-1:CW];
	assign s_axis_tready = (state_q == ST_LOAD);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign full   = (cnt_q == CNT_W'(MAX_POINTS));
	assign mem_we = accept && !full;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	ccmr_ram #(.WIDTH(2*CW), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({in_y, in_x}),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	assign mag_x = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
	assign mag_y = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
	assign dvd_x = (state_q == ST_CDIV) ? DIV_W'(mag_x) : dist_q;

	ccmr_div #(.N_W(DIV_W), .D_W(CNT_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(start_q), .dividend(dvd_x),
		.divisor(cnt_q), .done(done_x), .quotient(q_x)
	);
	ccmr_div #(.N_W(DIV_W), .D_W(CNT_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(start_q && (state_q == ST_CDIV)),
		.dividend(DIV_W'(mag_y)), .divisor(cnt_q), .done(done_y), .quotient(q_y)
	);

	assign dx = R_W'(signed'(rdata[CW-1:0])) - R_W'(cx_q);
	assign dy = R_W'(signed'(rdata[2*CW-1:CW])) - R_W'(cy_q);

	// one bit of the integer square root per cycle in ST_SQRT
	assign trial   = root_q + bit_q;
	assign fit     = n_q >= trial;
	assign n_nx    = fit ? n_q - trial : n_q;
	assign root_nx = fit ? (root_q >> 1) + bit_q : (root_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			idx_q       <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			drop_q      <= 1'b0;
			start_q     <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							sum_x_q <= sum_x_q + SUM_W'(in_x);
							sum_y_q <= sum_y_q + SUM_W'(in_y);
						end
						if (s_axis_tlast) begin
							start_q <= 1'b1;
							state_q <= ST_CDIV;
						end
					end
				end
				ST_CDIV: begin
					if (done_x && done_y) begin
						idx_q   <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_DAT;
				ST_DAT: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_SQL;
				ST_SQL: begin
					step_q  <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(R_W - 1)) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q + 1'b1 == cnt_q) begin
							start_q <= 1'b1;
							state_q <= ST_RDIV;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RDIV: begin
					if (done_x) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						cnt_q       <= '0;
						sum_x_q     <= '0;
						sum_y_q     <= '0;
						drop_q      <= 1'b0;
						state_q     <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CDIV && done_x && done_y) begin
			cx_q   <= sum_x_q[SUM_W-1] ? -q_x[CW-1:0] : q_x[CW-1:0];
			cy_q   <= sum_y_q[SUM_W-1] ? -q_y[CW-1:0] : q_y[CW-1:0];
			dist_q <= '0;
		end
		if (state_q == ST_DAT) begin
			adx_q <= dx[R_W-1] ? R_W'(-dx) : R_W'(dx);
			ady_q <= dy[R_W-1] ? R_W'(-dy) : R_W'(dy);
		end
		if (state_q == ST_MUL) begin
			sqx_q <= adx_q * adx_q;
			sqy_q <= ady_q * ady_q;
		end
		if (state_q == ST_SQL) begin
			n_q    <= sqx_q + sqy_q;
			root_q <= '0;
			bit_q  <= SQ_W'(1) << (SQ_W - 2);
		end
		if (state_q == ST_SQRT) begin
			n_q    <= n_nx;
			root_q <= root_nx;
			bit_q  <= bit_q >> 2;
			if (step_q == STEP_W'(R_W - 1)) begin
				dist_q <= dist_q + DIV_W'(root_nx[R_W-1:0]);
			end
		end
		if (out_load) begin
			out_data_q <= {{PAD_W{1'b0}}, drop_q, COUNT_OUT_W'(cnt_q), q_x[R_W-1:0],
				cy_q, cx_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assert property (@(posedge clk) disable iff (!arst_n) mem_we |-> cnt_q < CNT_W'(MAX_POINTS))
		else $error("point written past capacity");
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == ST_RD) |-> idx_q < cnt_q)
		else $error("scan index past stored count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> cnt_q != '0)
		else $error("empty cluster in computation");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (cnt_q == '0) && !drop_q && (state_q == ST_LOAD))
		else $error("cluster state not cleared at result");
endmodule
